// File: rtl/mpq_pkg.sv
// Shared constants and types for the min-priority queue.
package mpq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int OCC_W    = $clog2(CAPACITY + 1);

    // request actions
    localparam logic [1:0] ACT_INSERT      = 2'd0;
    localparam logic [1:0] ACT_TAKE_MIN    = 2'd1;
    localparam logic [1:0] ACT_TAKE_OLDEST = 2'd2;

    // result status
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    localparam logic [DATA_W-1:0] EMPTY_MIN_VALUE    = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] EMPTY_OLDEST_VALUE = 32'hFFFF_FFFF;

    // per-cell control from the sequencer
    typedef struct packed {
        logic active;   // cell holds a live entry
        logic shift;    // take the right neighbor's entry
        logic load;     // take the insert value
    } cell_ctl_t;

    // running minimum handed left to right through the chain
    typedef struct packed {
        logic                     valid;
        logic                     have;
        logic [IDX_W-1:0]         idx;
        logic signed [DATA_W-1:0] value;
    } scan_t;

endpackage

// File: rtl/mpq_cell.sv
// One queue slot: holds an entry, shifts toward the front, and joins the minimum scan.
module mpq_cell (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mpq_pkg::cell_ctl_t               ctl,
    input  logic [mpq_pkg::IDX_W-1:0]        cell_idx,
    input  logic signed [mpq_pkg::DATA_W-1:0] load_value,
    input  logic signed [mpq_pkg::DATA_W-1:0] right_data,
    output logic signed [mpq_pkg::DATA_W-1:0] data,
    input  mpq_pkg::scan_t                   scan_in,
    output mpq_pkg::scan_t                   scan_out
);
    import mpq_pkg::*;

    logic signed [DATA_W-1:0] data_reg;
    scan_t                    scan_reg;
    scan_t                    scan_next;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            data_reg <= load_value;
        end
        else if (ctl.shift)
        begin
            data_reg <= right_data;
        end
    end

    // strict less-than keeps the earliest of equal minima
    always_comb
    begin
        scan_next = scan_in;
        if (scan_in.valid && ctl.active && (!scan_in.have || (data_reg < scan_in.value)))
        begin
            scan_next.have  = 1'b1;
            scan_next.idx   = cell_idx;
            scan_next.value = data_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_reg <= '0;
        end
        else
        begin
            scan_reg <= scan_next;
        end
    end

    assign data     = data_reg;
    assign scan_out = scan_reg;

endmodule

// File: rtl/min_priority_queue_top.sv
// Top level of the min-priority queue: request sequencer, cell chain and result register.
//
// Bounded min-priority queue of CAPACITY signed 32-bit entries kept in arrival order.
// Request channel (s_*): s_tuser carries the action (insert, take-min, take-oldest),
// s_tdata the value to insert. Result channel (m_*): m_tdata carries the removed
// value, m_tuser the status (ok, empty, full). Every request beat yields one result beat.
// Sequencing: one request at a time. Insert, take-oldest, an empty take-min and the
// unused action code go from the request beat straight to the finish step. A take-min
// on a non-empty queue first sends a running minimum through the CAPACITY-cell chain,
// one cell per cycle, and reaches the finish step once it leaves the tail cell.
// The removal closes the gap as the result is registered: every cell from the removed
// slot onward copies its right neighbor.
// The result sits in an output register; the next request is taken while that
// beat still waits. If the receiver stalls, the sequencer holds the following
// result in its finish step until the register frees up, and takes no new request.
// Reset (rst_n low, async) empties the queue and drops any pending result beat.
module min_priority_queue_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    input  logic [1:0]  s_tuser,   // [1:0] action
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] result_value
    output logic [1:0]  m_tuser    // [1:0] status
);
    import mpq_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    logic [1:0]               state_reg, state_next;
    logic [1:0]               act_reg;
    logic signed [DATA_W-1:0] val_reg;
    logic [OCC_W-1:0]         occ_reg, occ_next;
    logic [IDX_W-1:0]         pos_reg;
    logic signed [DATA_W-1:0] min_reg;

    logic              m_valid_reg;
    logic [DATA_W-1:0] m_data_reg;
    logic [1:0]        m_user_reg;

    logic in_fire;
    logic slot_free;
    logic fin_fire;
    logic scan_start;

    logic [DATA_W-1:0] res_next;
    logic [1:0]        status_next;
    logic              do_shift;
    logic              do_load;
    logic [IDX_W-1:0]  shift_pos;

    cell_ctl_t                ctl    [CAPACITY];
    logic signed [DATA_W-1:0] cell_data [CAPACITY];
    scan_t                    scan_link [CAPACITY+1];

    assign s_tready  = (state_reg == S_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign slot_free = !m_valid_reg || m_tready;
    assign fin_fire  = (state_reg == S_FINISH) && slot_free;
    assign scan_start = in_fire && (s_tuser == ACT_TAKE_MIN) && (occ_reg != '0);

    // head of the scan chain: nothing seen yet
    always_comb
    begin
        scan_link[0]       = '0;
        scan_link[0].valid = scan_start;
    end

    // --- cell chain ---
    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] right_data;

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign right_data = cell_data[gi];
            end
            else
            begin : g_mid
                assign right_data = cell_data[gi+1];
            end

            always_comb
            begin
                ctl[gi].active = (OCC_W'(gi) < occ_reg);
                ctl[gi].shift  = do_shift && (IDX_W'(gi) >= shift_pos);
                ctl[gi].load   = do_load && (OCC_W'(gi) == occ_reg);
            end

            mpq_cell u_cell (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctl        (ctl[gi]),
                .cell_idx   (IDX_W'(gi)),
                .load_value (val_reg),
                .right_data (right_data),
                .data       (cell_data[gi]),
                .scan_in    (scan_link[gi]),
                .scan_out   (scan_link[gi+1])
            );
        end
    endgenerate

    // --- finish step decode ---
    always_comb
    begin
        res_next    = '0;
        status_next = STAT_OK;
        occ_next    = occ_reg;
        do_shift    = 1'b0;
        do_load     = 1'b0;
        shift_pos   = '0;
        case (act_reg)
            ACT_INSERT:
            begin
                if (occ_reg == OCC_W'(CAPACITY))
                begin
                    status_next = STAT_FULL;
                end
                else
                begin
                    do_load  = fin_fire;
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
            ACT_TAKE_MIN:
            begin
                if (occ_reg == '0)
                begin
                    res_next    = EMPTY_MIN_VALUE;
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    res_next  = min_reg;
                    do_shift  = fin_fire;
                    shift_pos = pos_reg;
                    occ_next  = occ_reg - OCC_W'(1);
                end
            end
            ACT_TAKE_OLDEST:
            begin
                if (occ_reg == '0)
                begin
                    res_next    = EMPTY_OLDEST_VALUE;
                    status_next = STAT_EMPTY;
                end
                else
                begin
                    res_next = cell_data[0];
                    do_shift = fin_fire;
                    occ_next = occ_reg - OCC_W'(1);
                end
            end
            default:
            begin
                res_next = '0;
            end
        endcase
    end

    // --- sequencer ---
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = scan_start ? S_SCAN : S_FINISH;
                end
            end
            S_SCAN:
            begin
                if (scan_link[CAPACITY].valid)
                begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fin_fire)
            begin
                occ_reg     <= occ_next;
                m_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            act_reg <= s_tuser;
            val_reg <= s_tdata;
        end
        if ((state_reg == S_SCAN) && scan_link[CAPACITY].valid)
        begin
            pos_reg <= scan_link[CAPACITY].idx;
            min_reg <= scan_link[CAPACITY].value;
        end
        if (fin_fire)
        begin
            m_data_reg <= res_next;
            m_user_reg <= status_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

`ifndef SYNTHESIS
    // occupancy never runs past the store
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(CAPACITY))
        else $error("occupancy above capacity");

    // the scan result only reaches the tail while the sequencer waits for it
    a_scan_tail: assert property (@(posedge clk) disable iff (!rst_n)
        scan_link[CAPACITY].valid |-> (state_reg == S_SCAN))
        else $error("scan result outside scan state");

    // a successful insert grows the queue by one
    a_insert_grow: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_fire && (act_reg == ACT_INSERT) && (occ_reg != OCC_W'(CAPACITY)))
        |=> (occ_reg == $past(occ_reg) + OCC_W'(1)))
        else $error("insert did not grow occupancy");

    // an empty status is only reported from an empty queue
    a_empty_status: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_fire && (status_next == STAT_EMPTY)) |-> (occ_reg == '0))
        else $error("empty status with entries held");
`endif

endmodule

// File: sim/tb_top.sv
// Testbench for the min-priority queue: directed, random traffic checked against a queue model.
module tb_top;
    import mpq_pkg::*;

    // action code the block ignores
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic signed [DATA_W-1:0] INT_MIN_VAL = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] INT_MAX_VAL = 32'sh7FFF_FFFF;

    typedef struct {
        logic [1:0]               action;
        logic signed [DATA_W-1:0] value;
        int                       gap;      // idle cycles before this beat
        bit                       drain;    // hold until every result is back
    } request_t;

    typedef struct {
        logic signed [DATA_W-1:0] value;
        logic [1:0]               status;
    } outcome_t;

    logic              clk;
    logic              rst_n    = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [DATA_W-1:0] s_tdata  = '0;
    logic [1:0]        s_tuser  = ACT_INSERT;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [DATA_W-1:0] m_tdata;
    logic [1:0]        m_tuser;

    request_t request_queue[$];
    outcome_t awaited_outcomes[$];
    int       errors = 0;

    // queue model: arrival order, front at index 0
    logic signed [DATA_W-1:0] model_vals [CAPACITY];
    int                       model_count = 0;

    min_priority_queue_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        #1_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // Applies one request to the model and returns the result beat it should produce.
    function automatic outcome_t queue_apply(logic [1:0] act, logic signed [DATA_W-1:0] val);
        outcome_t res;
        int       pos;
        res.value  = '0;
        res.status = STAT_OK;
        pos        = -1;
        case (act)
            ACT_INSERT:
                if (model_count >= CAPACITY)
                    res.status = STAT_FULL;
                else
                begin
                    model_vals[model_count] = val;
                    model_count++;
                end
            ACT_TAKE_MIN:
                if (model_count == 0)
                begin
                    res.value  = EMPTY_MIN_VALUE;
                    res.status = STAT_EMPTY;
                end
                else
                begin
                    // strict less-than keeps the earliest of equal minima
                    pos = 0;
                    for (int i = 1; i < model_count; i++)
                        if (model_vals[i] < model_vals[pos])
                            pos = i;
                end
            ACT_TAKE_OLDEST:
                if (model_count == 0)
                begin
                    res.value  = EMPTY_OLDEST_VALUE;
                    res.status = STAT_EMPTY;
                end
                else
                    pos = 0;
            default: ;
        endcase
        if (pos >= 0)
        begin
            res.value = model_vals[pos];
            for (int i = pos; i + 1 < model_count; i++)
                model_vals[i] = model_vals[i + 1];
            model_count--;
        end
        return res;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return 0;
        if (roll < 94)
            return $urandom_range(3, 1);
        return $urandom_range(30, 8);
    endfunction

    function automatic void add_request(logic [1:0] act, logic signed [DATA_W-1:0] val,
                                        int gap, bit drain);
        request_t req;
        req.action = act;
        req.value  = val;
        req.gap    = gap;
        req.drain  = drain;
        request_queue.push_back(req);
    endfunction

    // Request driver: predicts each accepted beat, then loads the next one.
    always @(posedge clk or negedge rst_n)
    begin
        request_t req;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= ACT_INSERT;
        end
        else
        begin
            if (s_tvalid && s_tready)
                awaited_outcomes.push_back(queue_apply(s_tuser, s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (request_queue.size() == 0)
                    s_tvalid <= 1'b0;
                else if (request_queue[0].gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    request_queue[0].gap--;
                end
                else if (request_queue[0].drain && awaited_outcomes.size() != 0)
                    s_tvalid <= 1'b0;
                else
                begin
                    req = request_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= req.value;
                    s_tuser  <= req.action;
                end
            end
        end
    end

    // Result monitor with random backpressure; quiet stretches come and go.
    int  stall_left = 0;
    int  rx_cycles  = 0;
    bit  rx_calm    = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t exp_out;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_outcomes.size() == 0)
                begin
                    $error("result beat with nothing expected: value %0d status %0d",
                           $signed(m_tdata), m_tuser);
                    errors++;
                end
                else
                begin
                    exp_out = awaited_outcomes.pop_front();
                    if (m_tdata !== exp_out.value)
                    begin
                        $error("result_value: expected %0d, got %0d",
                               exp_out.value, $signed(m_tdata));
                        errors++;
                    end
                    if (m_tuser !== exp_out.status)
                    begin
                        $error("status: expected %0d, got %0d", exp_out.status, m_tuser);
                        errors++;
                    end
                end
            end

            rx_cycles++;
            if (rx_cycles % 256 == 0)
                rx_calm = ($urandom_range(3) == 0);

            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!rx_calm && $urandom_range(3) == 0)
                    stall_left = pick_gap();
            end
        end
    end

    // Stimulus and end of run
    initial
    begin
        int  ins_pct;
        int  roll;
        bit  tx_calm;
        logic [1:0] act;
        logic signed [DATA_W-1:0] val;

        // empty queue: both removals and the ignored code
        add_request(ACT_TAKE_MIN,    '0, 0, 1'b0);
        add_request(ACT_TAKE_OLDEST, '0, 1, 1'b0);
        add_request(ACT_UNUSED,      32'sh5A5A_A5A5, 0, 1'b0);
        // fill to capacity with extremes and repeated minima
        add_request(ACT_INSERT, 32'sd7,  0, 1'b0);
        add_request(ACT_INSERT, 32'sd3,  0, 1'b0);
        add_request(ACT_INSERT, INT_MIN_VAL, 0, 1'b0);
        add_request(ACT_INSERT, INT_MAX_VAL, 2, 1'b0);
        add_request(ACT_INSERT, -32'sd1, 0, 1'b0);
        add_request(ACT_INSERT, 32'sd0,  0, 1'b0);
        add_request(ACT_INSERT, 32'sd3,  0, 1'b0);
        add_request(ACT_INSERT, INT_MIN_VAL, 0, 1'b0);
        for (int i = 0; i < 8; i++)
            add_request(ACT_INSERT, $urandom, 0, 1'b0);
        // full queue
        add_request(ACT_INSERT,      32'sh1234_5678, 0, 1'b0);
        add_request(ACT_UNUSED,      '0, 0, 1'b0);
        // two equal minima: the earlier must go first
        add_request(ACT_TAKE_MIN,    '0, 0, 1'b0);
        add_request(ACT_TAKE_MIN,    '0, 3, 1'b0);
        add_request(ACT_TAKE_OLDEST, '0, 0, 1'b0);
        add_request(ACT_TAKE_MIN,    '0, 0, 1'b0);

        // random traffic in segments that lean toward filling or emptying
        ins_pct = 50;
        tx_calm = 1'b0;
        for (int i = 0; i < 600; i++)
        begin
            if (i % 40 == 0)
            begin
                case ($urandom_range(2))
                    0:       ins_pct = 30;
                    1:       ins_pct = 50;
                    default: ins_pct = 80;
                endcase
                tx_calm = ($urandom_range(3) == 0);
            end

            roll = $urandom_range(99);
            if (roll < 3)
                act = ACT_UNUSED;
            else if (roll < ins_pct)
                act = ACT_INSERT;
            else if ($urandom_range(9) < 6)
                act = ACT_TAKE_MIN;
            else
                act = ACT_TAKE_OLDEST;

            roll = $urandom_range(99);
            if (roll < 45)
                val = $urandom;
            else if (roll < 85)
                val = $signed($urandom_range(8)) - 4;    // duplicates for tie-breaks
            else
            begin
                case ($urandom_range(3))
                    0:       val = INT_MIN_VAL;
                    1:       val = INT_MAX_VAL;
                    2:       val = -32'sd1;
                    default: val = 32'sd0;
                endcase
            end

            add_request(act, val, tx_calm ? 0 : pick_gap(),
                        (i == 0) || ($urandom_range(99) == 0));
        end

        @(negedge clk);
        while (request_queue.size() != 0 || s_tvalid || awaited_outcomes.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);

        if (errors == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
